// ===== hw/rtl/rsa_pkg.sv =====
// ----------------------------------------------------------------------------
// rsa_pkg
// shared types and constants of the reference counted slot allocator
// ----------------------------------------------------------------------------
`default_nettype none

package rsa_pkg;

   localparam int unsigned SLOTS  = 4;
   localparam int unsigned IDX_W  = 2;
   localparam int unsigned CNT_W  = 3;
   localparam int unsigned USES_W = 16;

   localparam logic [CNT_W-1:0]  SLOTS_CNT = CNT_W'(SLOTS);
   localparam logic [USES_W-1:0] USES_MAX  = '1;

   typedef enum logic [2:0] {
      KIND_ALLOC   = 3'd0,
      KIND_RETAIN  = 3'd1,
      KIND_RELEASE = 3'd2,
      KIND_READ    = 3'd3,
      KIND_SET_X   = 3'd4,
      KIND_SET_Y   = 3'd5,
      KIND_SET_XY  = 3'd6,
      KIND_FLUSH   = 3'd7
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [IDX_W-1:0]   slot;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]    slot_out;
      logic                failed;
      logic signed [31:0]  x_out;
      logic signed [31:0]  y_out;
      logic [USES_W-1:0]   use_count;
      logic                redraw;
      logic [CNT_W-1:0]    free_count;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rsa_core.sv =====
// ----------------------------------------------------------------------------
// rsa_core
// slot pool state: free stack, positions, use counts and change flag
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_core (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            take,
   input  wire rsa_pkg::req_type req,
   output rsa_pkg::rsp_type     rsp
);

   logic [rsa_pkg::IDX_W-1:0]  free_stack_ff [rsa_pkg::SLOTS];
   logic [rsa_pkg::IDX_W-1:0]  free_stack_in [rsa_pkg::SLOTS];
   logic [rsa_pkg::CNT_W-1:0]  depth_ff, depth_in;
   logic signed [31:0]         slot_x_ff [rsa_pkg::SLOTS];
   logic signed [31:0]         slot_x_in [rsa_pkg::SLOTS];
   logic signed [31:0]         slot_y_ff [rsa_pkg::SLOTS];
   logic signed [31:0]         slot_y_in [rsa_pkg::SLOTS];
   logic [rsa_pkg::USES_W-1:0] uses_ff [rsa_pkg::SLOTS];
   logic [rsa_pkg::USES_W-1:0] uses_in [rsa_pkg::SLOTS];
   logic                       changed_ff, changed_in;

   logic [rsa_pkg::CNT_W-1:0]  depth_dec;
   logic [rsa_pkg::IDX_W-1:0]  top_slot;
   logic [rsa_pkg::IDX_W-1:0]  s;
   logic [rsa_pkg::USES_W-1:0] cur_uses;

   assign depth_dec = depth_ff - rsa_pkg::CNT_W'(1);
   assign top_slot  = free_stack_ff[depth_dec[rsa_pkg::IDX_W-1:0]];
   assign s         = req.slot;
   assign cur_uses  = uses_ff[s];

   always_comb begin
      free_stack_in = free_stack_ff;
      depth_in      = depth_ff;
      slot_x_in     = slot_x_ff;
      slot_y_in     = slot_y_ff;
      uses_in       = uses_ff;
      changed_in    = changed_ff;
      rsp           = '0;
      rsp.slot_out  = s;

      unique case (req.kind)
         rsa_pkg::KIND_ALLOC: begin
            if (depth_ff == '0) begin
               rsp.slot_out = '0;
               rsp.failed   = 1'b1;
            end else begin
               depth_in            = depth_dec;
               slot_x_in[top_slot] = req.pos_x;
               slot_y_in[top_slot] = req.pos_y;
               uses_in[top_slot]   = rsa_pkg::USES_W'(1);
               rsp.slot_out        = top_slot;
               rsp.x_out           = req.pos_x;
               rsp.y_out           = req.pos_y;
               rsp.use_count       = rsa_pkg::USES_W'(1);
            end
         end
         rsa_pkg::KIND_FLUSH: begin
            rsp.redraw = changed_ff;
            changed_in = 1'b0;
         end
         default: begin
            if (cur_uses == '0) begin
               rsp.failed = 1'b1;
            end else begin
               unique case (req.kind)
                  rsa_pkg::KIND_RETAIN: begin
                     if (cur_uses != rsa_pkg::USES_MAX) begin
                        uses_in[s] = cur_uses + rsa_pkg::USES_W'(1);
                     end
                  end
                  rsa_pkg::KIND_RELEASE: begin
                     uses_in[s] = cur_uses - rsa_pkg::USES_W'(1);
                     if (cur_uses == rsa_pkg::USES_W'(1) && depth_ff < rsa_pkg::SLOTS_CNT) begin
                        free_stack_in[depth_ff[rsa_pkg::IDX_W-1:0]] = s;
                        depth_in = depth_ff + rsa_pkg::CNT_W'(1);
                     end
                  end
                  rsa_pkg::KIND_SET_X: begin
                     if (slot_x_ff[s] != req.pos_x) begin
                        slot_x_in[s] = req.pos_x;
                        changed_in   = 1'b1;
                     end
                  end
                  rsa_pkg::KIND_SET_Y: begin
                     if (slot_y_ff[s] != req.pos_y) begin
                        slot_y_in[s] = req.pos_y;
                        changed_in   = 1'b1;
                     end
                  end
                  rsa_pkg::KIND_SET_XY: begin
                     if (slot_x_ff[s] != req.pos_x || slot_y_ff[s] != req.pos_y) begin
                        slot_x_in[s] = req.pos_x;
                        slot_y_in[s] = req.pos_y;
                        changed_in   = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp.x_out     = slot_x_in[s];
               rsp.y_out     = slot_y_in[s];
               rsp.use_count = uses_in[s];
            end
         end
      endcase
      rsp.free_count = depth_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rsa_pkg::SLOTS; i++) begin
            free_stack_ff[i] <= rsa_pkg::IDX_W'(rsa_pkg::SLOTS - 1 - i);
            uses_ff[i]       <= '0;
         end
         depth_ff   <= rsa_pkg::SLOTS_CNT;
         changed_ff <= 1'b0;
      end else if (take) begin
         free_stack_ff <= free_stack_in;
         uses_ff       <= uses_in;
         depth_ff      <= depth_in;
         changed_ff    <= changed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         slot_x_ff <= slot_x_in;
         slot_y_ff <= slot_y_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/refcounted_slot_allocator.sv =====
// response: registered, valid in the cycle after the request is accepted
// throughput: one request per cycle while rsp_ready is high, limited by the single response register
// the response register refills in the cycle it is drained, so no bubble under stall release
// reset: synchronous; all slots free, slot 0 handed out first, change flag clear
// positions are unknown until a slot is first allocated
// ----------------------------------------------------------------------------
// refcounted_slot_allocator
// reference counted slot pool with lifo free stack and registered response
// ----------------------------------------------------------------------------
`default_nettype none

module refcounted_slot_allocator (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire rsa_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsa_pkg::rsp_type      rsp_payload
);

   logic             rsp_valid_ff, rsp_valid_in;
   rsa_pkg::rsp_type rsp_ff;
   rsa_pkg::rsp_type core_rsp;
   logic             take;

   assign req_ready = !reset && (rsp_ready || !rsp_valid_ff);
   assign take      = req_valid && req_ready;

   rsa_core u_core (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .req   (req_payload),
      .rsp   (core_rsp)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rsa_checker.sv =====
// ----------------------------------------------------------------------------
// rsa_checker
// port level checks of the slot allocator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire rsa_pkg::rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no response after accepted request");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.failed |->
         rsp_payload.use_count == '0 && rsp_payload.x_out == '0 &&
         rsp_payload.y_out == '0 && !rsp_payload.redraw)
      else $error("failed response carries data");

   a_in_use_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.use_count != '0 |->
         rsp_payload.free_count < rsa_pkg::SLOTS_CNT)
      else $error("slot in use but pool reports all free");

   a_free_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.free_count <= rsa_pkg::SLOTS_CNT)
      else $error("free count beyond pool size");

endmodule

bind refcounted_slot_allocator rsa_checker u_rsa_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
